### src/two_stage_gyro_moving_average_core_assert.svh
// -----------------------------------------------------------------------------
// Two-stage gyro moving average: assertion macros
// Shared assertion forms for the checker of the averaging core.
// -----------------------------------------------------------------------------
`ifndef TWO_STAGE_GYRO_MOVING_AVERAGE_CORE_ASSERT_SVH
`define TWO_STAGE_GYRO_MOVING_AVERAGE_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TSGMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TSGMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tsgma_pkg.sv
// -----------------------------------------------------------------------------
// Two-stage gyro moving average package
// Word types, codes and sequencer states shared by the averaging core.
// -----------------------------------------------------------------------------
package tsgma_pkg;

  // Width of a gyro reading and of every mean.
  localparam int DATA_W = 10;

  // Zero-rate offset after reset.
  localparam logic [DATA_W-1:0] OFFSET_RESET = 10'd600;

  // Codes of the action field.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_REFILL = 1'b1;

  // Input word.
  typedef struct packed {
    logic              action;
    logic [DATA_W-1:0] sample;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [DATA_W-1:0] latest;
    logic [DATA_W-1:0] long_mean;
  } out_word_t;

  // Operations of the shared adder.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_WSUB,
    S_WADD,
    S_WDIV,
    S_MSUB,
    S_MADD,
    S_LDIV,
    S_DONE
  } state_t;

endpackage

### src/tsgma_ram.sv
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module tsgma_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/tsgma_alu.sv
// -----------------------------------------------------------------------------
// Shared adder
// One adder that adds or subtracts the second operand from the first.
// -----------------------------------------------------------------------------
module tsgma_alu #(
  parameter int W = 16
) (
  input  tsgma_pkg::alu_op_t op,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output logic [W-1:0]       res
);

  logic         sub;
  logic [W-1:0] b_eff;

  // Subtraction adds the complement with a carry in.
  assign sub   = (op == tsgma_pkg::ALU_SUB);
  assign b_eff = sub ? ~b : b;
  assign res   = a + b_eff + W'(sub);

endmodule

### src/two_stage_gyro_moving_average_core.sv
// -----------------------------------------------------------------------------
// Two-stage gyro moving average core
// Smooths gyro readings through a window mean, decimated into a second store
// whose mean is reported with every word.
//
//   Channel | Signals                      | Fields
//   input   | in_valid, in_stall, in_data  | in_data.action, in_data.sample
//   output  | out_valid, out_stall, out_data | out_data.latest, out_data.long_mean
//   config  | cfg_we, cfg_data             | zero-rate offset
//
// A sample word runs through S_WSUB, S_WADD and S_DONE before the next accept;
// a sample that stores a new window mean also passes S_WDIV, S_MSUB, S_MADD and
// S_LDIV, since the shared adder updates both running sums and each mean is one
// multiply by a constant reciprocal. A refill word runs a fill pass, one entry of
// each store written per cycle, then S_DONE. After reset a fill pass loads both
// stores before any word is taken.
// A stalled result holds the sequencer in its last state until it is taken.
// -----------------------------------------------------------------------------
module two_stage_gyro_moving_average_core #(
  parameter int WINDOW     = 4,
  parameter int MEAN_COUNT = 4,
  parameter int DECIMATION = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tsgma_pkg::in_word_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tsgma_pkg::out_word_t              out_data,
  input  logic                              cfg_we,
  input  logic [tsgma_pkg::DATA_W-1:0]      cfg_data
);

  localparam int DW     = tsgma_pkg::DATA_W;
  localparam int WSUM_W = $clog2(WINDOW << DW);
  localparam int MSUM_W = $clog2(MEAN_COUNT << DW);
  localparam int ALU_W  = (WSUM_W > MSUM_W) ? WSUM_W : MSUM_W;
  localparam int WAW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MAW    = (MEAN_COUNT > 1) ? $clog2(MEAN_COUNT) : 1;
  localparam int FILL_N = (WINDOW > MEAN_COUNT) ? WINDOW : MEAN_COUNT;
  localparam int FCW    = (FILL_N > 1) ? $clog2(FILL_N) : 1;
  localparam int PHW    = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  // Reciprocals that turn each truncated mean into a multiply and a shift.
  // They are exact for every sum the stores can hold.
  localparam int WSH    = WSUM_W + $clog2(WINDOW);
  localparam int MSH    = MSUM_W + $clog2(MEAN_COUNT);
  localparam logic [WSUM_W:0] W_RECIP =
    (WSUM_W + 1)'(((1 << WSH) + WINDOW - 1) / WINDOW);
  localparam logic [MSUM_W:0] M_RECIP =
    (MSUM_W + 1)'(((1 << MSH) + MEAN_COUNT - 1) / MEAN_COUNT);

  tsgma_pkg::state_t  state;
  tsgma_pkg::state_t  state_next;

  logic [DW-1:0]      offset;
  logic [DW-1:0]      fill_val;
  logic               fill_report;
  logic [FCW-1:0]     fill_idx;
  logic [DW-1:0]      item_sample;
  logic [WAW-1:0]     ptr_w;
  logic [MAW-1:0]     ptr_m;
  logic [PHW-1:0]     phase;
  logic [WSUM_W-1:0]  wsum;
  logic [MSUM_W-1:0]  msum;
  logic [2*WSUM_W:0]  wprod;
  logic [2*MSUM_W:0]  mprod;
  logic [DW-1:0]      mean_new;
  logic [DW-1:0]      latest;
  logic [DW-1:0]      long_mean;

  tsgma_pkg::alu_op_t alu_op;
  logic [ALU_W-1:0]   alu_a;
  logic [ALU_W-1:0]   alu_b;
  logic [ALU_W-1:0]   alu_res;

  logic               win_we;
  logic [WAW-1:0]     win_waddr;
  logic [DW-1:0]      win_wdata;
  logic [DW-1:0]      win_rdata;
  logic               mean_we;
  logic [MAW-1:0]     mean_waddr;
  logic [DW-1:0]      mean_wdata;
  logic [DW-1:0]      mean_rdata;

  logic               accept;
  logic               out_free;
  logic               fill_last;

  // Handshake and step conditions.
  assign in_stall  = (state != tsgma_pkg::S_IDLE);
  assign accept    = in_valid && (state == tsgma_pkg::S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign fill_last = (fill_idx == FCW'(FILL_N - 1));

  // Truncated means of the running sums.
  assign wprod = (2 * WSUM_W + 1)'(wsum) * (2 * WSUM_W + 1)'(W_RECIP);
  assign mprod = (2 * MSUM_W + 1)'(msum) * (2 * MSUM_W + 1)'(M_RECIP);

  // Shared adder for the running sums.
  tsgma_alu #(.W(ALU_W)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // Window store, a circular buffer whose pointer marks the oldest reading.
  tsgma_ram #(.WIDTH(DW), .DEPTH(WINDOW)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .raddr (ptr_w),
    .rdata (win_rdata)
  );

  // Store of decimated window means, also circular.
  tsgma_ram #(.WIDTH(DW), .DEPTH(MEAN_COUNT)) u_mean_ram (
    .clk   (clk),
    .we    (mean_we),
    .waddr (mean_waddr),
    .wdata (mean_wdata),
    .raddr (ptr_m),
    .rdata (mean_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsgma_pkg::S_FILL;
    end else begin
      state <= state_next;
    end
  end

  // Next state, adder operands and store writes.
  always_comb begin
    state_next = state;
    alu_op     = tsgma_pkg::ALU_ADD;
    alu_a      = '0;
    alu_b      = '0;
    win_we     = 1'b0;
    win_waddr  = ptr_w;
    win_wdata  = item_sample;
    mean_we    = 1'b0;
    mean_waddr = ptr_m;
    mean_wdata = mean_new;
    unique case (state)
      tsgma_pkg::S_FILL: begin
        win_we     = ({1'b0, fill_idx} < (FCW + 1)'(WINDOW));
        win_waddr  = fill_idx[WAW-1:0];
        win_wdata  = fill_val;
        mean_we    = ({1'b0, fill_idx} < (FCW + 1)'(MEAN_COUNT));
        mean_waddr = fill_idx[MAW-1:0];
        mean_wdata = fill_val;
        if (fill_last) begin
          state_next = fill_report ? tsgma_pkg::S_DONE : tsgma_pkg::S_IDLE;
        end
      end
      tsgma_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (in_data.action == tsgma_pkg::ACT_REFILL) ?
                       tsgma_pkg::S_FILL : tsgma_pkg::S_WSUB;
        end
      end
      tsgma_pkg::S_WSUB: begin
        alu_op     = tsgma_pkg::ALU_SUB;
        alu_a      = ALU_W'(wsum);
        alu_b      = ALU_W'(win_rdata);
        win_we     = 1'b1;
        state_next = tsgma_pkg::S_WADD;
      end
      tsgma_pkg::S_WADD: begin
        alu_a      = ALU_W'(wsum);
        alu_b      = ALU_W'(item_sample);
        state_next = (phase == '0) ? tsgma_pkg::S_WDIV : tsgma_pkg::S_DONE;
      end
      tsgma_pkg::S_WDIV: begin
        state_next = tsgma_pkg::S_MSUB;
      end
      tsgma_pkg::S_MSUB: begin
        alu_op     = tsgma_pkg::ALU_SUB;
        alu_a      = ALU_W'(msum);
        alu_b      = ALU_W'(mean_rdata);
        mean_we    = 1'b1;
        state_next = tsgma_pkg::S_MADD;
      end
      tsgma_pkg::S_MADD: begin
        alu_a      = ALU_W'(msum);
        alu_b      = ALU_W'(mean_new);
        state_next = tsgma_pkg::S_LDIV;
      end
      tsgma_pkg::S_LDIV: begin
        state_next = tsgma_pkg::S_DONE;
      end
      tsgma_pkg::S_DONE: begin
        if (out_free) begin
          state_next = tsgma_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tsgma_pkg::S_IDLE;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= tsgma_pkg::OFFSET_RESET;
    end else if (cfg_we) begin
      offset <= cfg_data;
    end
  end

  // Output register; a finished word waits here while the next is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tsgma_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tsgma_pkg::S_DONE && out_free) begin
      out_data.latest    <= latest;
      out_data.long_mean <= long_mean;
    end
  end

  // Fill sequencing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_val    <= tsgma_pkg::OFFSET_RESET;
      fill_report <= 1'b0;
      fill_idx    <= '0;
    end else if (accept && in_data.action == tsgma_pkg::ACT_REFILL) begin
      fill_val    <= offset;
      fill_report <= 1'b1;
      fill_idx    <= '0;
    end else if (state == tsgma_pkg::S_FILL && !fill_last) begin
      fill_idx <= fill_idx + FCW'(1);
    end
  end

  // Store pointers and decimation phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_w <= '0;
      ptr_m <= '0;
      phase <= '0;
    end else begin
      case (state)
        tsgma_pkg::S_FILL: begin
          if (fill_last) begin
            ptr_w <= '0;
            ptr_m <= '0;
            phase <= '0;
          end
        end
        tsgma_pkg::S_WSUB: begin
          ptr_w <= (ptr_w == WAW'(WINDOW - 1)) ? '0 : ptr_w + WAW'(1);
        end
        tsgma_pkg::S_WADD: begin
          phase <= (phase == PHW'(DECIMATION - 1)) ? '0 : phase + PHW'(1);
        end
        tsgma_pkg::S_MSUB: begin
          ptr_m <= (ptr_m == MAW'(MEAN_COUNT - 1)) ? '0 : ptr_m + MAW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Running sums, means and result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_sample <= in_data.sample;
    end
    case (state)
      tsgma_pkg::S_FILL: begin
        if (fill_last) begin
          wsum      <= WSUM_W'(fill_val) * WSUM_W'(WINDOW);
          msum      <= MSUM_W'(fill_val) * MSUM_W'(MEAN_COUNT);
          latest    <= fill_val;
          long_mean <= fill_val;
        end
      end
      tsgma_pkg::S_WSUB: begin
        wsum <= alu_res[WSUM_W-1:0];
      end
      tsgma_pkg::S_WADD: begin
        wsum   <= alu_res[WSUM_W-1:0];
        latest <= item_sample;
      end
      tsgma_pkg::S_WDIV: begin
        mean_new <= wprod[WSH +: DW];
      end
      tsgma_pkg::S_MSUB: begin
        msum <= alu_res[MSUM_W-1:0];
      end
      tsgma_pkg::S_MADD: begin
        msum <= alu_res[MSUM_W-1:0];
      end
      tsgma_pkg::S_LDIV: begin
        long_mean <= mprod[MSH +: DW];
      end
      default: begin
      end
    endcase
  end

endmodule

### src/tsgma_chk.sv
// -----------------------------------------------------------------------------
// Two-stage gyro moving average checker
// Port-level assertions on the averaging core, attached by bind.
// -----------------------------------------------------------------------------
`include "two_stage_gyro_moving_average_core_assert.svh"

module tsgma_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input tsgma_pkg::in_word_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input tsgma_pkg::out_word_t out_data
);

  // The fill pass after reset keeps the input closed.
  `TSGMA_ASSERT_SAME(a_fill_after_reset, clk, rst, $past(rst), in_stall, "input open during fill pass")

  // An accepted word keeps the block busy in the cycle after it is taken.
  `TSGMA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accepted twice in a row")

  // A new result only appears at the end of busy work.
  `TSGMA_ASSERT_SAME(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall), "result without work")

  // A stalled result word is held.
  `TSGMA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind two_stage_gyro_moving_average_core tsgma_chk u_tsgma_chk (.*);

### tb/sv/two_stage_gyro_moving_average_core_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Two-stage gyro moving average core testbench
// Sends sample and refill words to the averaging core and compares each result
// word against an in-bench model of the window and mean stores. The run starts
// with a short directed table. Random phases follow, each under a different
// zero-rate offset and a different mix of sender gaps and receiver stalls. In
// one phase the receiver holds off for a long stretch to back the core up.
// -----------------------------------------------------------------------------
module two_stage_gyro_moving_average_core_tb;
  import tsgma_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int WIN_LEN         = 4;
  localparam int MEAN_LEN        = 4;
  localparam int DEC_LEN         = 4;
  localparam int PHASES          = 5;
  localparam int WORDS_PER_PHASE = 200;
  localparam int SETTLE_CYCLES   = 40;
  localparam int LONG_HOLD       = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DIR_ROWS        = 24;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_style_t;

  // One row of the directed table. A typed row carries its own expected word.
  typedef struct packed {
    logic              typed;
    logic              action;
    logic [DATA_W-1:0] sample;
    logic [DATA_W-1:0] latest;
    logic [DATA_W-1:0] long_mean;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        cfg_we;
  logic [DATA_W-1:0] cfg_data;

  // Model state: window taps, decimated mean taps, decimation phase, offset.
  logic [DATA_W-1:0] win_taps [WIN_LEN];
  logic [DATA_W-1:0] mean_taps [MEAN_LEN];
  int                dec_phase;
  logic [DATA_W-1:0] zero_offset;

  out_word_t    expected_out [$];
  dir_row_t     directed_rows [DIR_ROWS];
  stall_style_t stall_style;
  int           gap_max;
  int           burst_left;
  int           hold_asked;
  int           hold_granted;
  int           hold_left;
  int           pattern_pos;
  int           err_count;
  int           words_sent;
  int           refills_sent;
  int           results_checked;
  int           input_held;
  int           cycle_count;

  two_stage_gyro_moving_average_core #(
    .WINDOW    (WIN_LEN),
    .MEAN_COUNT(MEAN_LEN),
    .DECIMATION(DEC_LEN)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Advances the filter model by one word and returns the result it predicts.
  function automatic out_word_t advance_filter(in_word_t w);
    out_word_t r;
    int        acc;
    if (w.action == ACT_REFILL) begin
      for (int i = 0; i < WIN_LEN; i++) win_taps[i] = zero_offset;
      for (int i = 0; i < MEAN_LEN; i++) mean_taps[i] = zero_offset;
      dec_phase = 0;
    end else begin
      for (int i = 0; i < WIN_LEN - 1; i++) win_taps[i] = win_taps[i + 1];
      win_taps[WIN_LEN - 1] = w.sample;
      // The window mean is taken after the new reading is in.
      if (dec_phase == 0) begin
        acc = 0;
        for (int i = 0; i < WIN_LEN; i++) acc += win_taps[i];
        for (int i = 0; i < MEAN_LEN - 1; i++) mean_taps[i] = mean_taps[i + 1];
        mean_taps[MEAN_LEN - 1] = DATA_W'(acc / WIN_LEN);
      end
      dec_phase = (dec_phase + 1) % DEC_LEN;
    end
    acc = 0;
    for (int i = 0; i < MEAN_LEN; i++) acc += mean_taps[i];
    r.latest    = win_taps[WIN_LEN - 1];
    r.long_mean = DATA_W'(acc / MEAN_LEN);
    return r;
  endfunction

  // Offers one word and holds it until the core takes it.
  task automatic send_word(in_word_t w, logic typed, out_word_t typed_exp);
    out_word_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_filter(w);
    expected_out.push_back(typed ? typed_exp : predicted);
    words_sent++;
    if (w.action == ACT_REFILL) refills_sent++;
  endtask

  // Sends a word as part of a burst, with a random gap once a burst runs out.
  task automatic offer_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    send_word(w, 1'b0, '0);
  endtask

  function automatic in_word_t make_random_word();
    in_word_t w;
    w.action = ($urandom_range(0, 19) == 0) ? ACT_REFILL : ACT_SAMPLE;
    case ($urandom_range(0, 9))
      0: w.sample = '0;
      1: w.sample = '1;
      default: w.sample = DATA_W'($urandom_range(0, 1023));
    endcase
    return w;
  endfunction

  // Drains the core, lets it settle, then writes the offset register.
  task automatic program_offset(logic [DATA_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    zero_offset = value;
  endtask

  // Receiver: stalls per the current style, or holds off for a long stretch.
  always @(negedge clk) begin : recv_stall
    logic stall_next;
    stall_next = 1'b0;
    if (hold_left == 0 && hold_granted != hold_asked) begin
      hold_left    = LONG_HOLD;
      hold_granted = hold_asked;
    end
    if (hold_left != 0) begin
      stall_next = 1'b1;
      hold_left--;
    end else begin
      case (stall_style)
        STALL_RANDOM: stall_next = ($urandom_range(0, 2) == 0);
        STALL_PATTERN: begin
          stall_next  = (pattern_pos < 5);
          pattern_pos = (pattern_pos + 1) % 13;
        end
        default: stall_next = 1'b0;
      endcase
    end
    out_stall <= stall_next;
  end

  // Result checker: each taken word is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall) input_held++;
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          report_mismatch("result word with none expected", out_data, 0);
        end else begin
          if (out_data.latest !== expected_out[0].latest)
            report_mismatch("latest", out_data.latest, expected_out[0].latest);
          if (out_data.long_mean !== expected_out[0].long_mean)
            report_mismatch("long_mean", out_data.long_mean, expected_out[0].long_mean);
          void'(expected_out.pop_front());
          results_checked++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_out.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_word_t  w;
    out_word_t typed_exp;
    logic [DATA_W-1:0] new_offset;

    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    stall_style  = STALL_NONE;
    gap_max      = 0;
    burst_left   = 0;
    hold_asked   = 0;
    hold_granted = 0;
    hold_left    = 0;
    pattern_pos  = 0;
    err_count    = 0;
    words_sent   = 0;
    refills_sent = 0;
    results_checked = 0;
    input_held   = 0;
    cycle_count  = 0;
    zero_offset  = OFFSET_RESET;
    dec_phase    = 0;
    for (int i = 0; i < WIN_LEN; i++) win_taps[i] = OFFSET_RESET;
    for (int i = 0; i < MEAN_LEN; i++) mean_taps[i] = OFFSET_RESET;

    // Directed table, run under the reset offset. Refill rows read back the
    // offset in both fields; sample rows go through the model.
    directed_rows = '{
      '{1'b1, ACT_REFILL, 10'd0,    OFFSET_RESET, OFFSET_RESET},
      '{1'b0, ACT_SAMPLE, 10'd0,    10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd1023, 10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd1023, 10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd1023, 10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd1023, 10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'h155,  10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'h2AA,  10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd0,    10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd1023, 10'd0, 10'd0},
      '{1'b1, ACT_REFILL, 10'd1023, OFFSET_RESET, OFFSET_RESET},
      '{1'b0, ACT_SAMPLE, 10'd1023, 10'd0, 10'd0},
      '{1'b1, ACT_REFILL, 10'h2AA,  OFFSET_RESET, OFFSET_RESET},
      '{1'b1, ACT_REFILL, 10'h155,  OFFSET_RESET, OFFSET_RESET},
      '{1'b0, ACT_SAMPLE, 10'd0,    10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd0,    10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd0,    10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd0,    10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd0,    10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd1,    10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd512,  10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd511,  10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd1022, 10'd0, 10'd0},
      '{1'b0, ACT_SAMPLE, 10'd0,    10'd0, 10'd0}
    };

    // Synchronous reset, released at a falling clock edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, words back to back with a randomly stalling receiver.
    stall_style = STALL_RANDOM;
    for (int r = 0; r < DIR_ROWS; r++) begin
      w.action            = directed_rows[r].action;
      w.sample            = directed_rows[r].sample;
      typed_exp.latest    = directed_rows[r].latest;
      typed_exp.long_mean = directed_rows[r].long_mean;
      send_word(w, directed_rows[r].typed, typed_exp);
    end

    // Random phases: each one sets a new offset and its own idling mix.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: new_offset = '1;
        1: new_offset = '0;
        default: new_offset = DATA_W'($urandom_range(0, 1023));
      endcase
      case (p)
        0: begin stall_style = STALL_NONE;    gap_max = 0;  end
        1: begin stall_style = STALL_RANDOM;  gap_max = 6;  end
        2: begin stall_style = STALL_PATTERN; gap_max = 3;  end
        3: begin stall_style = STALL_RANDOM;  gap_max = 10; end
        default: begin stall_style = STALL_PATTERN; gap_max = 2; end
      endcase
      program_offset(new_offset);
      // Long hold-off while the sender keeps offering words.
      if (p == 2) hold_asked++;
      repeat (WORDS_PER_PHASE) offer_word(make_random_word());
    end

    // Drain, then watch a little longer for stray results.
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d refills) under %0d offset settings, %0d results checked.",
             words_sent, refills_sent, PHASES + 1, results_checked);
    $display("Input was held off for %0d cycles while a word was offered.", input_held);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/tsgma_pkg.sv
src/tsgma_ram.sv
src/tsgma_alu.sv
src/two_stage_gyro_moving_average_core.sv
src/tsgma_chk.sv
tb/sv/two_stage_gyro_moving_average_core_tb.sv
